// ===== hdl/resource_admission_with_wait_queue_macros.svh =====
// Assertion macros shared by the checker of the admission block.
// Stand-alone header; no other file is needed.
`ifndef RESOURCE_ADMISSION_WITH_WAIT_QUEUE_MACROS_SVH
`define RESOURCE_ADMISSION_WITH_WAIT_QUEUE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("admission block check failed");

// Next-cycle implication, masked during reset.
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("admission block check failed");

`endif

// ===== hdl/rau_pkg.sv =====
// Shared types, codes and constants of the resource admission block.
// No dependencies; every module refers to it by scoped names.
package rau_pkg;

  localparam int RING_DEPTH_DEF = 32;
  localparam int SLOT_COUNT_DEF = 32;
  localparam int MAX_RESULTS    = 32;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
  localparam int IN_TDATA_W     = 56;
  localparam int OUT_TDATA_W    = 56;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_RAM   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_CORES = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_DISK  = 2'd2;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_RELEASED = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_t;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_ADD = 1'b1
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_FIT,
    S_XCHK,
    S_XREL,
    S_DCHK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] ram;
    logic [7:0]  cores;
    logic [15:0] disk;
  } job_t;

  typedef struct packed {
    logic [15:0] ram;
    logic [7:0]  cores;
    logic [15:0] disk;
  } avail_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  job_id;
    logic [4:0]  slot_handle;
    avail_t      free;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctl_t;

  typedef struct packed {
    logic scan_clr;
    logic scan_step;
    logic claim;
    logic vacate;
  } slot_ctl_t;

  typedef struct packed {
    logic hit;
    logic at_last;
  } slot_stat_t;

  localparam avail_t RESET_AVAIL = '{ram: 16'd4096, cores: 8'd8, disk: 16'd1024};

endpackage

// ===== hdl/rau_alu.sv =====
// Shared resource arithmetic: subtract with fit test, or saturating add.
// Depends on rau_pkg.
module rau_alu (
  input  rau_pkg::alu_op_t op,
  input  rau_pkg::avail_t  a,
  input  rau_pkg::job_t    b,
  output rau_pkg::avail_t  y,
  output logic             fits
);

  logic [16:0] ram_s;
  logic [8:0]  cores_s;
  logic [16:0] disk_s;

  always_comb begin
    if (op == rau_pkg::ALU_ADD) begin
      ram_s   = {1'b0, a.ram} + {1'b0, b.ram};
      cores_s = {1'b0, a.cores} + {1'b0, b.cores};
      disk_s  = {1'b0, a.disk} + {1'b0, b.disk};
    end else begin
      ram_s   = {1'b0, a.ram} - {1'b0, b.ram};
      cores_s = {1'b0, a.cores} - {1'b0, b.cores};
      disk_s  = {1'b0, a.disk} - {1'b0, b.disk};
    end
  end

  always_comb begin
    case (op)
      rau_pkg::ALU_ADD: begin
        // clamp at the field maximum
        y.ram   = ram_s[16]  ? 16'hFFFF : ram_s[15:0];
        y.cores = cores_s[8] ? 8'hFF    : cores_s[7:0];
        y.disk  = disk_s[16] ? 16'hFFFF : disk_s[15:0];
      end
      default: begin
        y.ram   = ram_s[15:0];
        y.cores = cores_s[7:0];
        y.disk  = disk_s[15:0];
      end
    endcase
  end

  // no borrow anywhere: the job fits
  assign fits = !ram_s[16] && !cores_s[8] && !disk_s[16];

endmodule

// ===== hdl/rau_ring.sv =====
// Circular wait ring: job memory with head and tail pointers.
// Depends on rau_pkg.
module rau_ring #(
  parameter int RING_DEPTH = rau_pkg::RING_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rau_pkg::ring_ctl_t              ctl,
  input  rau_pkg::job_t                   wr_job,
  output rau_pkg::job_t                   rd_job,
  output logic [$clog2(RING_DEPTH)-1:0]   count,
  output logic                            full
);

  localparam int PW = $clog2(RING_DEPTH);

  rau_pkg::job_t   mem [RING_DEPTH];
  logic [PW-1:0]   head;
  logic [PW-1:0]   tail;
  logic [PW-1:0]   head_next;
  logic [PW-1:0]   tail_next;
  logic [PW:0]     span;

  assign head_next = (head == PW'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == PW'(RING_DEPTH - 1)) ? '0 : tail + 1'b1;

  always_comb begin
    if (tail >= head) begin
      span = {1'b0, tail} - {1'b0, head};
    end else begin
      span = {1'b0, tail} + (PW + 1)'(RING_DEPTH) - {1'b0, head};
    end
  end

  assign count = span[PW-1:0];
  assign full  = (tail_next == head);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (ctl.pop) begin
        head <= head_next;
      end
      if (ctl.push) begin
        tail <= tail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wr_job;
    end
    rd_job <= mem[head];
  end

endmodule

// ===== hdl/rau_slots.sv =====
// Job slots: busy flags, per-slot job record memory and a chunked free-slot scan.
// Depends on rau_pkg.
module rau_slots #(
  parameter int SLOT_COUNT = rau_pkg::SLOT_COUNT_DEF,
  parameter int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rau_pkg::slot_ctl_t   ctl,
  input  logic [SW-1:0]        claim_slot,
  input  rau_pkg::job_t        claim_job,
  input  logic [SW-1:0]        rel_slot,
  output logic                 busy_bit,
  output rau_pkg::job_t        rec_job,
  output rau_pkg::slot_stat_t  stat,
  output logic [SW-1:0]        hit_slot
);

  localparam int NCHUNK = (SLOT_COUNT + 7) / 8;
  localparam int PADN   = NCHUNK * 8;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  logic [SLOT_COUNT-1:0] busy;
  rau_pkg::job_t         rec_mem [SLOT_COUNT];
  logic [CW-1:0]         chunk;
  logic [PADN-1:0]       free_pad;
  logic [7:0]            sel;
  logic [2:0]            bit_pos;
  logic [CW+2:0]         wide_slot;

  // slots past the end read as taken
  assign free_pad = PADN'(~busy);
  assign sel      = free_pad[int'(chunk) * 8 +: 8];

  always_comb begin
    stat.hit = 1'b0;
    bit_pos  = '0;
    for (int b = 7; b >= 0; b--) begin
      if (sel[b]) begin
        stat.hit = 1'b1;
        bit_pos  = 3'(b);
      end
    end
  end

  assign stat.at_last = (chunk == CW'(NCHUNK - 1));
  assign wide_slot    = {chunk, bit_pos};
  assign hit_slot     = wide_slot[SW-1:0];
  assign busy_bit     = (int'(rel_slot) < SLOT_COUNT) ? busy[rel_slot] : 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= '0;
      chunk <= '0;
    end else begin
      if (ctl.scan_clr) begin
        chunk <= '0;
      end else if (ctl.scan_step) begin
        chunk <= chunk + 1'b1;
      end
      if (ctl.claim) begin
        busy[claim_slot] <= 1'b1;
      end
      if (ctl.vacate) begin
        busy[rel_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.claim) begin
      rec_mem[claim_slot] <= claim_job;
    end
    rec_job <= rec_mem[rel_slot];
  end

endmodule

// ===== hdl/resource_admission_with_wait_queue.sv =====
// Resource admission with wait ring: top level, sequencer and result staging.
// Depends on rau_pkg, rau_alu, rau_ring and rau_slots.
//
// Usage: each slave transaction is one command. s_tuser[0] is the operation
// (0 launch, 1 exit); s_tdata carries the job id, its memory, core and disk
// needs and, for an exit, the slot handle. Every command yields one or more
// master transactions; m_tuser is the status and m_tlast marks the final
// result of a command. The cfg channel rewrites a total and reloads its free
// counter; issue it only while no command is in flight. cfg_ready is always high.
// Timing: a command goes through one shared subtract/add unit under a small
// sequencer. The free-slot scan reads 8 slots a cycle. A launch scans for a
// free slot, tests the fit and finishes; an exit checks and releases its slot,
// then scans and tests the fit for each job it takes from the ring. s_tready
// is high only between commands.
// Results are staged one deep so the last flag is known before a result
// leaves; a stalled master side holds the output register and the sequencer
// waits, nothing is lost. Reset is synchronous: free counters return to the
// default totals, all slots go free, the ring empties and outputs go invalid.
module resource_admission_with_wait_queue #(
  parameter int RING_DEPTH = rau_pkg::RING_DEPTH_DEF,
  parameter int SLOT_COUNT = rau_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // request_id[7:0], ram_need[23:8], core_need[31:24], disk_need[47:32],
  // exit_slot[52:48], zero pad
  input  logic [rau_pkg::IN_TDATA_W-1:0]    s_tdata,
  // operation[0]
  input  logic [0:0]                        s_tuser,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // job_id[7:0], slot_handle[12:8], free_ram[28:13], free_cores[36:29],
  // free_disk[52:37], zero pad
  output logic [rau_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // status[2:0]
  output logic [2:0]                        m_tuser,
  output logic                              m_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rau_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rau_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  rau_pkg::state_t      state;
  rau_pkg::state_t      state_next;
  rau_pkg::job_t        job_q;
  logic [4:0]           es_q;
  logic                 drain_q;
  logic                 found_q;
  logic [SW-1:0]        fslot_q;
  logic [PW-1:0]        dcount;
  logic [rau_pkg::CNT_W-1:0] ncount;
  rau_pkg::avail_t      avail_q;
  rau_pkg::res_t        pend;
  logic                 pend_valid;
  rau_pkg::res_t        out_q;
  logic                 out_last;

  // sequencer strobes
  rau_pkg::ring_ctl_t   ring_ctl;
  rau_pkg::slot_ctl_t   slot_ctl;
  rau_pkg::slot_stat_t  slot_stat;
  rau_pkg::res_t        new_res;
  logic                 produce;
  logic                 avail_load;
  logic                 flush;
  rau_pkg::alu_op_t     alu_op;
  rau_pkg::job_t        alu_b;
  rau_pkg::avail_t      alu_y;
  logic                 alu_fits;

  rau_pkg::job_t        ring_rd;
  logic [PW-1:0]        ring_count;
  logic                 ring_full;
  rau_pkg::job_t        rec_rd;
  logic                 busy_bit;
  logic [SW-1:0]        hit_slot;

  logic [8:0]           es_wide;
  logic [SW-1:0]        es_idx;
  logic                 slot_live;
  logic                 out_free;
  logic                 can_prod;
  logic                 grant;

  assign es_wide   = 9'(es_q);
  assign es_idx    = es_wide[SW-1:0];
  // the named slot exists and holds a job
  assign slot_live = (es_wide < 9'(SLOT_COUNT)) && busy_bit;
  assign out_free  = !m_tvalid || m_tready;
  assign can_prod  = !pend_valid || out_free;
  assign grant     = found_q && alu_fits;

  rau_alu u_alu (
    .op   (alu_op),
    .a    (avail_q),
    .b    (alu_b),
    .y    (alu_y),
    .fits (alu_fits)
  );

  rau_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ring_ctl),
    .wr_job (job_q),
    .rd_job (ring_rd),
    .count  (ring_count),
    .full   (ring_full)
  );

  rau_slots #(
    .SLOT_COUNT (SLOT_COUNT),
    .SW         (SW)
  ) u_slots (
    .clk        (clk),
    .rst        (rst),
    .ctl        (slot_ctl),
    .claim_slot (fslot_q),
    .claim_job  (job_q),
    .rel_slot   (es_idx),
    .busy_bit   (busy_bit),
    .rec_job    (rec_rd),
    .stat       (slot_stat),
    .hit_slot   (hit_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    ring_ctl    = '0;
    slot_ctl    = '0;
    produce     = 1'b0;
    avail_load  = 1'b0;
    flush       = 1'b0;
    alu_op      = rau_pkg::ALU_SUB;
    alu_b       = job_q;
    new_res.status      = rau_pkg::ST_GRANTED;
    new_res.job_id      = job_q.id;
    new_res.slot_handle = 5'(fslot_q);
    new_res.free        = avail_q;

    case (state)
      rau_pkg::S_IDLE: begin
        s_tready      = 1'b1;
        slot_ctl.scan_clr = 1'b1;
        if (s_tvalid) begin
          state_next = s_tuser[0] ? rau_pkg::S_XCHK : rau_pkg::S_FIND;
        end
      end
      rau_pkg::S_FIND: begin
        // stop on the first chunk with a free slot, or at the last chunk
        if (slot_stat.hit || slot_stat.at_last) begin
          state_next = rau_pkg::S_FIT;
        end else begin
          slot_ctl.scan_step = 1'b1;
        end
      end
      rau_pkg::S_FIT: begin
        if (can_prod) begin
          if (drain_q) begin
            ring_ctl.pop = 1'b1;
          end
          if (grant) begin
            slot_ctl.claim = 1'b1;
            avail_load     = 1'b1;
            produce        = 1'b1;
            new_res.free   = alu_y;
            state_next     = drain_q ? rau_pkg::S_DCHK : rau_pkg::S_FIN;
          end else if (drain_q) begin
            // head does not fit: requeue at the tail and stop draining
            ring_ctl.push = 1'b1;
            state_next    = rau_pkg::S_FIN;
          end else if (ring_full) begin
            produce             = 1'b1;
            new_res.status      = rau_pkg::ST_DROPPED;
            new_res.slot_handle = '0;
            state_next          = rau_pkg::S_FIN;
          end else begin
            ring_ctl.push       = 1'b1;
            produce             = 1'b1;
            new_res.status      = rau_pkg::ST_QUEUED;
            new_res.slot_handle = '0;
            state_next          = rau_pkg::S_FIN;
          end
        end
      end
      rau_pkg::S_XCHK: begin
        if (slot_live) begin
          state_next = rau_pkg::S_XREL;
        end else begin
          produce             = 1'b1;
          new_res.status      = rau_pkg::ST_UNKNOWN;
          new_res.job_id      = '0;
          new_res.slot_handle = es_q;
          state_next          = rau_pkg::S_FIN;
        end
      end
      rau_pkg::S_XREL: begin
        alu_op              = rau_pkg::ALU_ADD;
        alu_b               = rec_rd;
        slot_ctl.vacate     = 1'b1;
        avail_load          = 1'b1;
        produce             = 1'b1;
        new_res.status      = rau_pkg::ST_RELEASED;
        new_res.job_id      = rec_rd.id;
        new_res.slot_handle = es_q;
        new_res.free        = alu_y;
        state_next          = rau_pkg::S_DCHK;
      end
      rau_pkg::S_DCHK: begin
        slot_ctl.scan_clr = 1'b1;
        if (dcount == '0 || ncount == rau_pkg::CNT_W'(rau_pkg::MAX_RESULTS)) begin
          state_next = rau_pkg::S_FIN;
        end else begin
          state_next = rau_pkg::S_FIND;
        end
      end
      rau_pkg::S_FIN: begin
        if (out_free) begin
          flush      = 1'b1;
          state_next = rau_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rau_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      drain_q    <= 1'b0;
      ncount     <= '0;
      avail_q    <= rau_pkg::RESET_AVAIL;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      // capture the command
      if (state == rau_pkg::S_IDLE && s_tvalid) begin
        job_q.id    <= s_tdata[7:0];
        job_q.ram   <= s_tdata[23:8];
        job_q.cores <= s_tdata[31:24];
        job_q.disk  <= s_tdata[47:32];
        es_q        <= s_tdata[52:48];
        drain_q     <= 1'b0;
        ncount      <= '0;
      end

      // hold scan result; while draining, load the ring head as the job
      if (state == rau_pkg::S_FIND) begin
        found_q <= slot_stat.hit;
        fslot_q <= hit_slot;
        if (drain_q) begin
          job_q <= ring_rd;
        end
      end

      if (avail_load) begin
        avail_q <= alu_y;
      end

      if (state == rau_pkg::S_XREL) begin
        drain_q <= 1'b1;
        dcount  <= ring_count;
      end
      if (ring_ctl.pop) begin
        dcount <= dcount - 1'b1;
      end

      // one-deep staging: a new result pushes the older one out, not last
      if (produce) begin
        if (pend_valid) begin
          out_q    <= pend;
          out_last <= 1'b0;
          m_tvalid <= 1'b1;
        end
        pend       <= new_res;
        pend_valid <= 1'b1;
        ncount     <= ncount + 1'b1;
      end

      if (flush) begin
        out_q      <= pend;
        out_last   <= 1'b1;
        m_tvalid   <= 1'b1;
        pend_valid <= 1'b0;
      end

      // a total write reloads its free counter
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rau_pkg::CFG_TOTAL_RAM:   avail_q.ram   <= cfg_data;
          rau_pkg::CFG_TOTAL_CORES: avail_q.cores <= cfg_data[7:0];
          rau_pkg::CFG_TOTAL_DISK:  avail_q.disk  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign cfg_ready = 1'b1;
  assign m_tdata   = {3'b000, out_q.free.disk, out_q.free.cores, out_q.free.ram,
                      out_q.slot_handle, out_q.job_id};
  assign m_tuser   = out_q.status;
  assign m_tlast   = out_last;

endmodule

// ===== hdl/rau_checker.sv =====
// Port-level checks of the admission block, attached by bind.
// Depends on rau_pkg and resource_admission_with_wait_queue_macros.svh.
`include "resource_admission_with_wait_queue_macros.svh"

module rau_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rau_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [2:0]                      m_tuser,
  input logic                            m_tlast
);

  // a stalled result holds
  `RAU_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // a command blocks the input for at least the next cycle
  `RAU_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

  // queued, dropped and unknown-slot results end their command
  `RAU_ASSERT_IMP(a_single_final, clk, rst, m_tvalid && (m_tuser == rau_pkg::ST_QUEUED || m_tuser == rau_pkg::ST_DROPPED || m_tuser == rau_pkg::ST_UNKNOWN), m_tlast)

  // queued and dropped results carry no slot
  `RAU_ASSERT_IMP(a_no_slot, clk, rst, m_tvalid && (m_tuser == rau_pkg::ST_QUEUED || m_tuser == rau_pkg::ST_DROPPED), m_tdata[12:8] == 5'd0)

endmodule

bind resource_admission_with_wait_queue rau_checker u_rau_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
